// File: hdl/csym_pkg.sv
package csym_pkg;

    // Default build values
    localparam int DEF_WINDOW        = 147;
    localparam int DEF_CENTRE_STEP   = 1;
    localparam int DEF_POSITION_BITS = 24;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int SECLEN_W   = 24;
    localparam int DIP_W      = 16;
    localparam int POS_OUT_W  = 24;
    localparam int SCORE_W    = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Reciprocal: 2^32 / divisor, one quotient bit per cycle
    localparam int DIV_STEPS = 33;
    localparam int QUO_W     = 33;

    // Score for a flat window: 100.0 in Q16.16
    localparam logic [SCORE_W-1:0] SCORE_FLAT    = 32'd6553600;
    localparam logic [DIP_W-1:0]   MIN_DIP_RESET = 16'd3;

    // Register word select (paddr[2])
    localparam logic REG_SECTION_LENGTH = 1'b0;
    localparam logic REG_MIN_DIP        = 1'b1;

    typedef struct packed {
        logic [SECLEN_W-1:0] section_length;
        logic [DIP_W-1:0]    min_dip;
    } t_cfg;

endpackage

// File: hdl/csym_regs.sv
module csym_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csym_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csym_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csym_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output csym_pkg::t_cfg                      o_cfg
);
    import csym_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write a register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.section_length <= '0;
            r_cfg.min_dip        <= MIN_DIP_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SECTION_LENGTH: r_cfg.section_length <= pwdata[SECLEN_W-1:0];
                REG_MIN_DIP:        r_cfg.min_dip        <= pwdata[DIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_SECTION_LENGTH: prdata = APB_DATA_W'(r_cfg.section_length);
            REG_MIN_DIP:        prdata = APB_DATA_W'(r_cfg.min_dip);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/csym_window.sv
module csym_window #(
    parameter int DEPTH  = 2 * (csym_pkg::DEF_WINDOW / 2) + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic [csym_pkg::SAMPLE_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0]               i_raddr0,
    input  logic [ADDR_W-1:0]               i_raddr1,
    output logic [csym_pkg::SAMPLE_W-1:0]   o_rdata0,
    output logic [csym_pkg::SAMPLE_W-1:0]   o_rdata1
);
    import csym_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_q0;
    logic [SAMPLE_W-1:0] r_q1;

    // Write the newest sample
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        r_q0 <= r_mem[i_raddr0];
        r_q1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_q0;
    assign o_rdata1 = r_q1;

endmodule

// File: hdl/csym_divider.sv
module csym_divider #(
    parameter int DIV_W = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [DIV_W-1:0]                i_divisor,
    output logic                            o_done,
    output logic [csym_pkg::SCORE_W-1:0]    o_quotient
);
    import csym_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;

    logic             w_bit;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;
    logic             w_ge;

    // Dividend is 2^32: a single one in the first step
    assign w_bit   = (r_cnt == CNT_W'(DIV_STEPS));
    assign w_trial = {r_rem, w_bit};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // Step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Restoring division, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    // Saturate a quotient of 2^32
    assign o_done     = r_done;
    assign o_quotient = r_quo[QUO_W-1] ? '1 : r_quo[SCORE_W-1:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("divider busy with spent count");

endmodule

// File: hdl/curvature_symmetry_score.sv
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_curvature, i_section_start
// result    out        o_out_valid / i_out_stall o_centre_position, o_score
// config    in         APB psel/penable/pready   section_length @0, min_dip @4
//
// A sample that scores no centre leaves the block idle. A scored centre reads one mirrored
// pair per cycle, and a weighted one is then run through the 33-step divider.
// Reset is synchronous; the window needs no clearing, as a scored centre reads only
// entries written in the current section.
// o_in_stall is high while scoring; a stalled result waits in the output register.
module curvature_symmetry_score #(
    parameter int WINDOW        = csym_pkg::DEF_WINDOW,
    parameter int CENTRE_STEP   = csym_pkg::DEF_CENTRE_STEP,
    parameter int POSITION_BITS = csym_pkg::DEF_POSITION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [csym_pkg::SAMPLE_W-1:0]       i_curvature,
    input  logic                                i_section_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [csym_pkg::POS_OUT_W-1:0]      o_centre_position,
    output logic [csym_pkg::SCORE_W-1:0]        o_score,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csym_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csym_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csym_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import csym_pkg::*;

    localparam int HALF     = WINDOW / 2;
    localparam int DEPTH    = 2 * HALF + 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int I_W      = $clog2(HALF + CENTRE_STEP + 1);
    localparam int EXT_W    = ((ADDR_W > I_W) ? ADDR_W : I_W) + 1;
    localparam int PHASE_W  = $clog2(CENTRE_STEP + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(HALF + 1);
    localparam int DIPS_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIPS_W + SUM_W;
    localparam int CMP_W    = ((POSITION_BITS > SECLEN_W) ? POSITION_BITS : SECLEN_W) + 1;
    localparam int PB       = POSITION_BITS;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_CTR   = 4'd1;
    localparam logic [3:0] S_RD_RIGHT = 4'd2;
    localparam logic [3:0] S_PAIRS    = 4'd3;
    localparam logic [3:0] S_DRAIN    = 4'd4;
    localparam logic [3:0] S_MUL      = 4'd5;
    localparam logic [3:0] S_START    = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    // Meaning of the read data returning this cycle
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_MIDL  = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;
    localparam logic [1:0] KIND_PAIR  = 2'd3;

    t_cfg w_cfg;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_kind, n_kind;
    logic [PB-1:0]       r_count;
    logic [ADDR_W-1:0]   r_ptr;
    logic [PHASE_W-1:0]  r_phase;
    logic [ADDR_W-1:0]   r_ctr;
    logic [PB-1:0]       r_d;
    logic [I_W-1:0]      r_i;
    logic [SAMPLE_W-1:0] r_mid, r_left, r_right;
    logic [SUM_W-1:0]    r_sum;
    logic [PROD_W-1:0]   r_prod;
    logic [SCORE_W-1:0]  r_score;
    logic                r_out_valid;
    logic [POS_OUT_W-1:0] r_out_pos;
    logic [SCORE_W-1:0]  r_out_score;

    logic                w_acc, w_full, w_we, w_late, w_on_grid, w_in_sect, w_go;
    logic [PB-1:0]       w_n, w_d;
    logic [ADDR_W-1:0]   w_ptr, w_ctr, w_ptr_next;
    logic [PHASE_W-1:0]  w_phase, w_phase_inc, w_phase_next;
    logic [I_W-1:0]      w_off;
    logic [EXT_W-1:0]    w_up_ext, w_down_ext;
    logic [ADDR_W-1:0]   w_raddr0, w_raddr1;
    logic [SAMPLE_W-1:0] w_q0, w_q1, w_absdiff;
    logic [DIPS_W-1:0]   w_dip;
    logic                w_weighted;
    logic [PROD_W-1:0]   w_prod;
    logic                w_div_done;
    logic [SCORE_W-1:0]  w_quotient;
    logic                w_out_free;

    csym_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Take a sample: section start clears position and phase first
    assign w_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_n       = i_section_start ? '0 : r_count;
    assign w_ptr     = i_section_start ? '0 : r_ptr;
    assign w_phase   = i_section_start ? '0 : r_phase;
    assign w_full    = &w_n;
    assign w_we      = w_acc && !w_full;
    assign w_late    = w_n >= PB'(WINDOW + HALF);
    assign w_d       = w_n - PB'(HALF);
    assign w_on_grid = (w_phase == '0);
    assign w_in_sect = (CMP_W'(w_d) + CMP_W'(WINDOW)) < CMP_W'(w_cfg.section_length);
    assign w_go      = w_we && w_late && w_on_grid && w_in_sect;

    assign w_ptr_next   = (w_ptr == ADDR_W'(DEPTH - 1)) ? '0 : w_ptr + ADDR_W'(1);
    assign w_phase_inc  = w_phase + PHASE_W'(1);
    assign w_phase_next = (w_phase_inc >= PHASE_W'(CENTRE_STEP)) ? '0 : w_phase_inc;
    assign w_ctr        = (w_ptr >= ADDR_W'(HALF)) ? w_ptr - ADDR_W'(HALF)
                                                   : w_ptr + ADDR_W'(DEPTH - HALF);

    // Mirrored read addresses around the centre
    assign w_off      = (r_state == S_PAIRS) ? r_i : I_W'(1);
    assign w_up_ext   = EXT_W'(r_ctr) + EXT_W'(w_off);
    assign w_down_ext = (EXT_W'(r_ctr) >= EXT_W'(w_off))
                      ? EXT_W'(r_ctr) - EXT_W'(w_off)
                      : EXT_W'(r_ctr) + EXT_W'(DEPTH) - EXT_W'(w_off);

    always_comb begin
        w_raddr1 = w_down_ext[ADDR_W-1:0];
        if (r_state == S_RD_CTR) begin
            w_raddr0 = r_ctr;
        end else if (w_up_ext >= EXT_W'(DEPTH)) begin
            w_raddr0 = ADDR_W'(w_up_ext - EXT_W'(DEPTH));
        end else begin
            w_raddr0 = w_up_ext[ADDR_W-1:0];
        end
    end

    csym_window #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_window (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_ptr),
        .i_wdata  (i_curvature),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_q0),
        .o_rdata1 (w_q1)
    );

    // Dip, weight and product
    assign w_absdiff  = (w_q0 > w_q1) ? w_q0 - w_q1 : w_q1 - w_q0;
    assign w_dip      = (DIPS_W'(r_left) - DIPS_W'(r_mid)) + (DIPS_W'(r_right) - DIPS_W'(r_mid));
    assign w_weighted = (r_mid < r_left) && (r_mid < r_right)
                     && (w_dip >= DIPS_W'(w_cfg.min_dip));
    assign w_prod     = w_dip * r_sum;

    csym_divider #(
        .DIV_W (PROD_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_divisor  (r_prod),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and read tag
    always_comb begin
        n_state = r_state;
        n_kind  = KIND_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) n_state = S_RD_CTR;
            end
            S_RD_CTR: begin
                n_kind  = KIND_MIDL;
                n_state = S_RD_RIGHT;
            end
            S_RD_RIGHT: begin
                n_kind  = KIND_RIGHT;
                n_state = (CENTRE_STEP > HALF) ? S_DRAIN : S_PAIRS;
            end
            S_PAIRS: begin
                n_kind = KIND_PAIR;
                if ((r_i + I_W'(CENTRE_STEP)) > I_W'(HALF)) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_MUL;
            S_MUL: begin
                n_state = ((r_sum == '0) || !w_weighted) ? S_OUT : S_START;
            end
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= KIND_NONE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            if (w_acc) begin
                r_count <= w_full ? w_n : w_n + PB'(1);
                r_ptr   <= w_full ? w_ptr : w_ptr_next;
                r_phase <= (w_we && w_late) ? w_phase_next : w_phase;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: latch centre, gather reads, form the score
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_ctr <= w_ctr;
            r_d   <= w_d;
        end
        case (r_kind)
            KIND_MIDL: begin
                r_mid  <= w_q0;
                r_left <= w_q1;
            end
            KIND_RIGHT: r_right <= w_q0;
            KIND_PAIR:  r_sum   <= r_sum + SUM_W'(w_absdiff);
            default: ;
        endcase
        if (r_state == S_RD_CTR) r_sum <= '0;
        if (r_state == S_RD_RIGHT) r_i <= I_W'(CENTRE_STEP);
        if (r_state == S_PAIRS) r_i <= r_i + I_W'(CENTRE_STEP);
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
            if (r_sum == '0) begin
                r_score <= SCORE_FLAT;
            end else if (!w_weighted) begin
                r_score <= '0;
            end
        end
        if (r_state == S_DIV && w_div_done) r_score <= w_quotient;
        if (r_state == S_OUT && w_out_free) begin
            r_out_pos   <= POS_OUT_W'(r_d);
            r_out_score <= r_score;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_centre_position = r_out_pos;
    assign o_score           = r_out_score;

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> r_out_valid)
        else $error("result not loaded into output register");

    a_pair_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind == KIND_PAIR) |-> (r_state == S_PAIRS || r_state == S_DRAIN))
        else $error("pair data returned outside the pair sweep");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_kind == KIND_NONE))
        else $error("product formed before window reads drained");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import csym_pkg::*;

    localparam int WINDOW      = DEF_WINDOW;
    localparam int HALF_WIN    = WINDOW / 2;
    localparam int WIN_DEPTH   = 2 * HALF_WIN + 1;
    localparam int CENTRE_STEP = DEF_CENTRE_STEP;
    localparam longint unsigned COUNT_MAX = (64'd1 << DEF_POSITION_BITS) - 64'd1;

    // Time to let scoring finish, with a margin on top
    localparam int SETTLE_CYCLES = 160;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [23:0] SECLEN_MAX = 24'hFFFFFF;
    localparam logic [15:0] FLAT_LEVEL = 16'h1000;

    typedef struct packed {
        logic [POS_OUT_W-1:0] position;
        logic [SCORE_W-1:0]   score;
    } t_centre_score;

    // Tracks the window, works out each centre score and checks the results
    class centre_scoreboard;
        logic [SAMPLE_W-1:0] window_mem [WIN_DEPTH];
        longint unsigned     next_index;
        int unsigned         step_phase;
        logic [SECLEN_W-1:0] section_length;
        logic [DIP_W-1:0]    min_dip;
        t_centre_score       pending_scores[$];
        int mismatches;
        int samples_taken;
        int centres_expected;
        int centres_checked;
        int flat_scores;
        int weighted_scores;

        function new();
            foreach (window_mem[k]) window_mem[k] = '0;
            next_index = 0;
            step_phase = 0;
            section_length = '0;
            min_dip = MIN_DIP_RESET;
            mismatches = 0;
            samples_taken = 0;
            centres_expected = 0;
            centres_checked = 0;
            flat_scores = 0;
            weighted_scores = 0;
        endfunction

        function void set_register(logic sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_SECTION_LENGTH) begin
                section_length = value[SECLEN_W-1:0];
            end else begin
                min_dip = value[DIP_W-1:0];
            end
        endfunction

        function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("MISMATCH %s: expected 0x%0h, got 0x%0h", what, want, got);
            end
        endfunction

        function int outstanding();
            return pending_scores.size();
        endfunction

        // Mirrored-pair sum, dip test and reciprocal for centre d
        function logic [SCORE_W-1:0] predict_centre_score(longint unsigned d);
            logic [SAMPLE_W-1:0] mid, left, right, a, b;
            logic [63:0] pair_sum, dip, quotient;
            bit weighted;
            mid = window_mem[d % WIN_DEPTH];
            left = window_mem[(d - 1) % WIN_DEPTH];
            right = window_mem[(d + 1) % WIN_DEPTH];
            pair_sum = '0;
            dip = '0;
            for (longint unsigned i = CENTRE_STEP; i <= HALF_WIN; i += CENTRE_STEP) begin
                a = window_mem[(d + i) % WIN_DEPTH];
                b = window_mem[(d - i) % WIN_DEPTH];
                pair_sum += (a > b) ? 64'(a - b) : 64'(b - a);
            end
            weighted = (mid < left) && (mid < right);
            if (weighted) begin
                dip = 64'(left - mid) + 64'(right - mid);
                weighted = (dip >= 64'(min_dip)) && (dip != 0);
            end
            if (pair_sum == 0) return SCORE_FLAT;
            if (!weighted) return '0;
            quotient = (64'd1 << 32) / (dip * pair_sum);
            return (quotient > 64'hFFFF_FFFF) ? '1 : quotient[SCORE_W-1:0];
        endfunction

        // Store one accepted word and queue the centre score it completes
        function void take_sample(logic [SAMPLE_W-1:0] curvature, logic section_start);
            longint unsigned n, d;
            bit on_grid;
            t_centre_score c;
            samples_taken++;
            if (section_start) begin
                next_index = 0;
                step_phase = 0;
            end
            n = next_index;
            if (n >= COUNT_MAX) return;
            window_mem[n % WIN_DEPTH] = curvature;
            next_index = n + 1;
            if (n < WINDOW + HALF_WIN) return;
            d = n - HALF_WIN;
            on_grid = (step_phase == 0);
            step_phase = (step_phase + 1 >= CENTRE_STEP) ? 0 : step_phase + 1;
            if (!on_grid) return;
            if (d + WINDOW >= 64'(section_length)) return;
            c.position = d[POS_OUT_W-1:0];
            c.score = predict_centre_score(d);
            if (c.score == SCORE_FLAT) flat_scores++;
            else if (c.score != 0) weighted_scores++;
            centres_expected++;
            pending_scores.push_back(c);
        endfunction

        function void check_centre(logic [POS_OUT_W-1:0] position, logic [SCORE_W-1:0] score);
            t_centre_score want;
            if (pending_scores.size() == 0) begin
                note_mismatch("centre_position, no score pending", '0, 64'(position));
                return;
            end
            want = pending_scores.pop_front();
            centres_checked++;
            if (position !== want.position) begin
                note_mismatch("centre_position", 64'(want.position), 64'(position));
            end
            if (score !== want.score) begin
                note_mismatch("score", 64'(want.score), 64'(score));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [SAMPLE_W-1:0] i_curvature = '0;
    logic i_section_start = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [POS_OUT_W-1:0] o_centre_position;
    logic [SCORE_W-1:0] o_score;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    int unsigned cycle_count = 0;
    int quiet_cycles = 0;
    int stall_run = 0;

    centre_scoreboard sb = new;

    curvature_symmetry_score dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_curvature       (i_curvature),
        .i_section_start   (i_section_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_centre_position (o_centre_position),
        .o_score           (o_score),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    // Hold both sides busy during one stretch in every four
    function automatic bit calm_stretch();
        return cycle_count[10:9] == 2'b11;
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    // Count cycles and end the run when nothing moves for too long
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Check each accepted result word, then pick the next stall
    always @(posedge i_clk) begin : result_side
        int run;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_centre(o_centre_position, o_score);
        end
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            i_out_stall <= 1'b1;
        end else begin
            run = calm_stretch() ? 0 : idle_length();
            stall_run <= (run > 0) ? run - 1 : 0;
            i_out_stall <= (run > 0);
        end
    end

    // Offer one curvature word after an optional gap and hold it until taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] curvature, input logic section_start);
        int gap;
        gap = calm_stretch() ? 0 : idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_curvature <= curvature;
        i_section_start <= section_start;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_sample(curvature, section_start);
    endtask

    // Setup phase, access phase until pready, then an idle phase
    task automatic apb_access(input logic write, input logic sel,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {sel, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic sel, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got, mask;
        mask = (sel == REG_SECTION_LENGTH) ? 32'(SECLEN_MAX) : 32'hFFFF;
        apb_access(1'b0, sel, '0, got);
        if ((got & mask) !== (want & mask)) begin
            sb.note_mismatch((sel == REG_SECTION_LENGTH) ? "section_length readback"
                                                         : "min_dip readback",
                             64'(want & mask), 64'(got & mask));
        end
    endtask

    task automatic write_register(input logic sel, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, sel, value, unused);
        sb.set_register(sel, value);
        check_register(sel, value);
    endtask

    // Drop valid, wait for every pending score, then let the block drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [SAMPLE_W-1:0] pattern [246];
        logic [SAMPLE_W-1:0] value;
        logic [DIP_W-1:0] dip_setting;
        int len, nsamp, mode, restart, level, r, sections;
        int base_items, base_results;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_register(REG_SECTION_LENGTH, '0);
        check_register(REG_MIN_DIP, 32'(MIN_DIP_RESET));

        // Section length still zero after reset: nothing may score
        for (int k = 0; k < 8; k++) send_sample(16'($urandom), k == 0);

        // Window symmetric about centre 147, so it scores flat; valleys to its right
        // cover a dip below the threshold, one just above, a tie, a peak and a
        // full-scale valley; the tail alternates extremes to break the symmetry
        foreach (pattern[k]) pattern[k] = FLAT_LEVEL;
        pattern[147] = 16'h0F00;
        pattern[150] = 16'h0FFF;
        pattern[153] = 16'h0FFE;
        pattern[156] = 16'h0F00;
        pattern[157] = 16'h0F00;
        pattern[160] = 16'hFFFF;
        pattern[162] = 16'hFFFF;
        pattern[163] = 16'h0000;
        pattern[164] = 16'hFFFF;
        for (int i = 1; i <= HALF_WIN; i++) pattern[147 - i] = pattern[147 + i];
        for (int k = 221; k < 246; k++) begin
            case (k % 4)
                0: pattern[k] = 16'hFFFF;
                1: pattern[k] = 16'h0000;
                2: pattern[k] = 16'h5555;
                default: pattern[k] = 16'hAAAA;
            endcase
        end
        settle();
        write_register(REG_SECTION_LENGTH, 32'(SECLEN_MAX));
        write_register(REG_MIN_DIP, 32'(MIN_DIP_RESET));
        foreach (pattern[k]) send_sample(pattern[k], k == 0);

        // Carry on without a section start: only the first centre fits the length
        settle();
        write_register(REG_SECTION_LENGTH, 32'd321);
        for (int k = 0; k < 3; k++) send_sample(16'($urandom), 1'b0);

        // Random sections until enough words and scores have gone through
        base_items = sb.samples_taken;
        base_results = sb.centres_expected;
        sections = 0;
        while ((sb.samples_taken - base_items < 200 || sb.centres_expected - base_results < 20)
               && sections < 8) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                len = $urandom_range(280, 294);
                nsamp = 225;
            end else if (r < 20) begin
                len = int'(SECLEN_MAX);
                nsamp = $urandom_range(221, 260);
            end else begin
                len = $urandom_range(295, 370);
                nsamp = len - 74 + $urandom_range(0, 3);
            end
            r = $urandom_range(0, 99);
            if (sections == 0) dip_setting = '0;
            else if (sections == 1 || r < 10) dip_setting = 16'hFFFF;
            else if (r < 25) dip_setting = '0;
            else dip_setting = 16'($urandom_range(1, 256));
            r = $urandom_range(0, 9);
            mode = (sections == 0) ? 1 : (r < 6) ? 0 : (r < 8) ? 1 : 2;
            restart = ($urandom_range(0, 5) == 0) ? $urandom_range(1, nsamp - 1) : -1;

            settle();
            write_register(REG_SECTION_LENGTH, 32'(len));
            write_register(REG_MIN_DIP, 32'(dip_setting));
            level = $urandom_range(0, 65535 - 255);
            for (int k = 0; k < nsamp; k++) begin
                case (mode)
                    0: begin
                        // drifting level with noise: frequent shallow valleys
                        level = level + $urandom_range(0, 511) - 256;
                        if (level < 0) level = 0;
                        if (level > 65535 - 255) level = 65535 - 255;
                        value = 16'(level + $urandom_range(0, 255));
                    end
                    1: value = 16'($urandom);
                    default: begin
                        // mostly constant, so many windows come out flat
                        value = ($urandom_range(0, 49) == 0) ? 16'($urandom) : 16'(level);
                    end
                endcase
                send_sample(value, k == 0 || k == restart);
            end
            sections++;
        end

        settle();
        $display("Checked %0d centre scores (%0d flat windows, %0d weighted dips) from %0d words,",
                 sb.centres_checked, sb.flat_scores, sb.weighted_scores, sb.samples_taken);
        $display("over %0d random sections after reset, extreme-length and boundary sections.",
                 sections);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: curvature_symmetry_score.f
hdl/csym_pkg.sv
hdl/csym_regs.sv
hdl/csym_window.sv
hdl/csym_divider.sv
hdl/curvature_symmetry_score.sv
tb/sv/tb.sv
